// ----- sv/cef_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cef_pkg: shared types and codes of the coalescing event fifo
// Request and response beats, the register set, the status, operation and
// register index codes.
// ----------------------------------------------------------------------------
package cef_pkg;

	// operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// status codes
	localparam logic [2:0] ST_APPENDED = 3'd0;
	localparam logic [2:0] ST_MERGED   = 3'd1;
	localparam logic [2:0] ST_DROPPED  = 3'd2;
	localparam logic [2:0] ST_IGNORED  = 3'd3;
	localparam logic [2:0] ST_POPPED   = 3'd4;
	localparam logic [2:0] ST_EMPTY    = 3'd5;

	// register indexes
	localparam logic [2:0] REG_LOWEST_KIND  = 3'd0;
	localparam logic [2:0] REG_HIGHEST_KIND = 3'd1;
	localparam logic [2:0] REG_ROT_KIND     = 3'd2;
	localparam logic [2:0] REG_FLY_KIND     = 3'd3;
	localparam logic [2:0] REG_FLY_UD_DIR   = 3'd4;
	localparam logic [2:0] REG_ROT_LEFT     = 3'd5;
	localparam logic [2:0] REG_ROT_RIGHT    = 3'd6;

	// register reset values
	localparam logic [3:0] RST_LOWEST_KIND  = 4'd0;
	localparam logic [3:0] RST_HIGHEST_KIND = 4'd7;
	localparam logic [3:0] RST_ROT_KIND     = 4'd7;
	localparam logic [3:0] RST_FLY_KIND     = 4'd6;
	localparam logic [3:0] RST_FLY_UD_DIR   = 4'd2;
	localparam logic [3:0] RST_ROT_LEFT     = 4'd0;
	localparam logic [3:0] RST_ROT_RIGHT    = 4'd1;

	typedef struct packed {
		logic              op;
		logic [3:0]        in_kind;
		logic [3:0]        in_direction;
		logic signed [15:0] in_amount;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [3:0]        out_kind;
		logic [3:0]        out_direction;
		logic signed [15:0] out_amount;
		logic [4:0]        fill_level;
	} rsp_t;

	// one stored event
	typedef struct packed {
		logic [3:0]        kind;
		logic [3:0]        direction;
		logic signed [15:0] amount;
	} entry_t;

	typedef struct packed {
		logic [3:0] lowest_kind;
		logic [3:0] highest_kind;
		logic [3:0] rot_kind;
		logic [3:0] fly_kind;
		logic [3:0] fly_ud_dir;
		logic [3:0] rot_left;
		logic [3:0] rot_right;
	} cfg_t;

endpackage
`default_nettype wire

// ----- sv/cef_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cef_cfg: register set
// Seven 4-bit registers written by index; indexes past the set are dropped.
// ----------------------------------------------------------------------------
module cef_cfg
	import cef_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  wire logic [2:0] wr_index,
	input  wire logic [3:0] wr_data,
	output cfg_t            cfg
);

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lowest_kind  <= RST_LOWEST_KIND;
			cfg_q.highest_kind <= RST_HIGHEST_KIND;
			cfg_q.rot_kind     <= RST_ROT_KIND;
			cfg_q.fly_kind     <= RST_FLY_KIND;
			cfg_q.fly_ud_dir   <= RST_FLY_UD_DIR;
			cfg_q.rot_left     <= RST_ROT_LEFT;
			cfg_q.rot_right    <= RST_ROT_RIGHT;
		end else if (wr_en) begin
			case (wr_index)
				REG_LOWEST_KIND:  cfg_q.lowest_kind  <= wr_data;
				REG_HIGHEST_KIND: cfg_q.highest_kind <= wr_data;
				REG_ROT_KIND:     cfg_q.rot_kind     <= wr_data;
				REG_FLY_KIND:     cfg_q.fly_kind     <= wr_data;
				REG_FLY_UD_DIR:   cfg_q.fly_ud_dir   <= wr_data;
				REG_ROT_LEFT:     cfg_q.rot_left     <= wr_data;
				REG_ROT_RIGHT:    cfg_q.rot_right    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- sv/cef_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cef_ram: event storage
// One write port, one registered read port; a write to the address being
// read in the same cycle is forwarded to the read register.
// ----------------------------------------------------------------------------
module cef_ram
	import cef_pkg::*;
#(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  entry_t                 wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output entry_t                 rd_data
);

	entry_t mem [DEPTH];
	entry_t rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read with write forwarding
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

// ----- sv/cef_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cef_ctrl: ring pointers, tail merge and pop logic
// The newest entry lives in a register so that merges never touch the
// memory; it is written back to its slot when a later event is appended.
// The memory read port presents the entry at the head whenever more than one entry is held.
// ----------------------------------------------------------------------------
module cef_ctrl
	import cef_pkg::*;
#(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4,
	parameter int CNT_W  = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  req_t                   req,
	input  cfg_t                   cfg,
	output rsp_t                   rsp,
	output logic [CNT_W-1:0]       count,
	output logic                   ram_wr_en,
	output logic [ADDR_W-1:0]      ram_wr_addr,
	output entry_t                 ram_wr_data,
	output logic [ADDR_W-1:0]      ram_rd_addr,
	input  entry_t                 ram_rd_data
);

	localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

	logic [ADDR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0]  cnt_q;
	entry_t            newest_q;

	logic [ADDR_W-1:0] head_d, tail_d, last_idx, tail_inc;
	logic [CNT_W-1:0]  cnt_d;
	entry_t            newest_d;
	entry_t            head_entry;
	logic              held, kind_bad, rot_merge, fly_merge;
	logic signed [16:0] sum_w;
	logic signed [15:0] sum_sat;
	logic              wr_en_c;

	// slot of the newest entry and next free slot
	assign last_idx = (tail_q == '0) ? LAST_SLOT : tail_q - ADDR_W'(1);
	assign tail_inc = (tail_q == LAST_SLOT) ? '0 : tail_q + ADDR_W'(1);

	// oldest entry: in the newest register when it is the only one held
	assign head_entry = (cnt_q == CNT_W'(1)) ? newest_q : ram_rd_data;

	assign held     = (cnt_q != '0);
	assign kind_bad = (req.in_kind < cfg.lowest_kind) || (req.in_kind > cfg.highest_kind);
	assign rot_merge = held && (req.in_kind == cfg.rot_kind) &&
		(newest_q.kind == cfg.rot_kind);
	assign fly_merge = held && (req.in_kind == cfg.fly_kind) &&
		(req.in_direction == cfg.fly_ud_dir) && (newest_q.kind == cfg.fly_kind) &&
		(newest_q.direction == cfg.fly_ud_dir);

	// saturating rotation sum
	assign sum_w = {newest_q.amount[15], newest_q.amount} + {req.in_amount[15], req.in_amount};
	always_comb begin
		if (sum_w[16] != sum_w[15]) begin
			sum_sat = sum_w[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			sum_sat = sum_w[15:0];
		end
	end

	// operation decode and next state
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		newest_d = newest_q;
		wr_en_c  = 1'b0;
		rsp.out_kind      = '0;
		rsp.out_direction = '0;
		rsp.out_amount    = '0;
		if (req.op == OP_POP) begin
			if (!held) begin
				rsp.status = ST_EMPTY;
			end else begin
				rsp.status        = ST_POPPED;
				rsp.out_kind      = head_entry.kind;
				rsp.out_direction = head_entry.direction;
				rsp.out_amount    = head_entry.amount;
				head_d = (head_q == LAST_SLOT) ? '0 : head_q + ADDR_W'(1);
				cnt_d  = cnt_q - CNT_W'(1);
			end
		end else if (kind_bad) begin
			rsp.status = ST_IGNORED;
		end else if (rot_merge) begin
			rsp.status         = ST_MERGED;
			newest_d.amount    = sum_sat;
			newest_d.direction = (!sum_sat[15] && (sum_sat != '0)) ?
				cfg.rot_left : cfg.rot_right;
		end else if (fly_merge) begin
			rsp.status      = ST_MERGED;
			newest_d.amount = req.in_amount;
		end else if (cnt_q >= FULL_CNT) begin
			rsp.status = ST_DROPPED;
		end else begin
			rsp.status         = ST_APPENDED;
			wr_en_c            = held;
			newest_d.kind      = req.in_kind;
			newest_d.direction = req.in_direction;
			newest_d.amount    = req.in_amount;
			tail_d = tail_inc;
			cnt_d  = cnt_q + CNT_W'(1);
		end
		// fill level, wrapped to the field width
		rsp.fill_level = 5'(cnt_d);
	end

	// pointer and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q  <= cnt_d;
		end
	end

	// newest entry
	always_ff @(posedge clk) begin
		if (accept) begin
			newest_q <= newest_d;
		end
	end

	// old newest entry goes to its slot when another is appended
	assign ram_wr_en   = accept && wr_en_c;
	assign ram_wr_addr = last_idx;
	assign ram_wr_data = newest_q;
	assign ram_rd_addr = accept ? head_d : head_q;
	assign count       = cnt_q;

endmodule
`default_nettype wire

// ----- sv/coalescing_event_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coalescing_event_fifo: event fifo that merges events at its tail
// Rotation pushes add into a rotation tail, fly up/down pushes replace a fly
// up/down tail, other in-range pushes append if room; pops return the oldest.
// ----------------------------------------------------------------------------
//  channel  signals                          beat
//  req      req_valid, req_stall, req        one push or pop
//  rsp      rsp_valid, rsp_stall, rsp        status and popped event
//  cfg      cfg_valid, cfg_ready, cfg_index  one register write (cfg_wdata)
//
//  One operation per cycle while req_stall is low: each beat is decoded and
//  applied in the cycle it is accepted; its response is in the output register in the next cycle.
//  The newest event sits in a register and the oldest is read ahead from
//  the memory, so a merge or pop needs no extra memory access.
//  req_stall is high only while a response waits under rsp_stall.
//  Reset empties the fifo and loads the register defaults; no clearing pass.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module coalescing_event_fifo
	import cef_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  req_t            req,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output rsp_t            rsp,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [3:0] cfg_wdata
);

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	cfg_t              cfg;
	rsp_t              rsp_d, rsp_q;
	logic              rsp_valid_q;
	logic              accept;
	logic [CNT_W-1:0]  count;
	logic              ram_wr_en;
	logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
	entry_t            ram_wr_data, ram_rd_data;

	// handshake
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	cef_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_wdata),
		.cfg      (cfg)
	);

	cef_ctrl #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.CNT_W  (CNT_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.req         (req),
		.cfg         (cfg),
		.rsp         (rsp_d),
		.count       (count),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data)
	);

	cef_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// count never passes the depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// every accepted beat leaves a response
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("accepted beat gave no response");

	// pop on empty reports empty with a zero event
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.op == OP_POP) && (count == '0)) |=>
		((rsp.status == ST_EMPTY) && (rsp.out_amount == '0) && (rsp.out_kind == '0)))
		else $error("pop on empty fifo misreported");

	// an append grows the fifo by one entry
	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (rsp_d.status == ST_APPENDED)) |=> (count == $past(count) + CNT_W'(1)))
		else $error("append did not add an entry");

endmodule
`default_nettype wire
